// File: sv/smax_pkg.sv
// ============================================================================
// smax_pkg
// Shared types and constants for the scatter-max table with argmax.
// ============================================================================
package smax_pkg;

    // Fixed field widths
    localparam int OPC_W    = 2;
    localparam int SEG_W    = 8;
    localparam int COL_W    = 4;
    localparam int SAMPLE_W = 32;
    localparam int ROW_W    = 16;

    // Command codes; the fourth code is unused and ignored
    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    // One table entry as stored in memory
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] max_value;
        logic [ROW_W-1:0]           arg_row;
    } t_entry;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the beat and launch the memory read
        logic exec;   // compare and write back, or return the read result
        logic sweep;  // write one empty entry of the clearing pass
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic sweep_last;  // clearing pass is at its last entry
    } t_stat;

endpackage

// File: sv/segment_max_with_argmax_core.sv
// ============================================================================
// segment_max_with_argmax_core
// Scatter-max table of SEGMENTS x FEATURES entries with argmax row tracking.
// ============================================================================
// A command beat is taken when start is high and busy is low. For update and
// read commands, the accept cycle launches the read of the entry memory, and
// the next cycle compares against the registered read data and writes back
// (update) or registers the result (read); busy is high in that compare cycle.
// A read result appears on o_valid for exactly one cycle, the cycle after the
// compare cycle, when busy is already low again, and cannot be held off by the
// receiver. A clear command, and reset itself, run a clearing pass that marks
// one entry empty per cycle; busy stays high until the pass has covered all
// SEGMENTS*FEATURES entries, and only then is the next command taken.
module segment_max_with_argmax_core
    import smax_pkg::*;
#(
    parameter int              SEGMENTS  = 256,
    parameter int              FEATURES  = 16,
    parameter longint unsigned ROW_LIMIT = 64'd65536
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OPC_W-1:0]           i_opcode,
    input  logic [SEG_W-1:0]           i_segment,
    input  logic [COL_W-1:0]           i_column,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [ROW_W-1:0]           i_source_row,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_max_value,
    output logic [ROW_W-1:0]           o_arg_row,
    output logic                       o_present
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequence commands and the clearing pass
    smax_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    // Hold the table and compute results
    smax_dpath #(
        .SEGMENTS  (SEGMENTS),
        .FEATURES  (FEATURES),
        .ROW_LIMIT (ROW_LIMIT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_opcode     (i_opcode),
        .i_segment    (i_segment),
        .i_column     (i_column),
        .i_sample     (i_sample),
        .i_source_row (i_source_row),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_max_value  (o_max_value),
        .o_arg_row    (o_arg_row),
        .o_present    (o_present)
    );

endmodule

// File: sv/smax_ctrl.sv
// ============================================================================
// smax_ctrl
// Controller: sequences the clearing pass and the accept-then-compare command flow.
// ============================================================================
module smax_ctrl
    import smax_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [OPC_W-1:0] i_opcode,
    input  t_stat            i_stat,
    output t_cmd             o_cmd,
    output logic             busy
);

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State register; reset starts with a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode commands
    always_comb begin
        o_cmd.load  = (r_state == ST_IDLE) && start;
        o_cmd.exec  = (r_state == ST_EXEC);
        o_cmd.sweep = (r_state == ST_CLEAR);
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// File: sv/smax_dpath.sv
// ============================================================================
// smax_dpath
// Datapath: entry memory, address check, compare and write-back, result regs.
// ============================================================================
module smax_dpath
    import smax_pkg::*;
#(
    parameter int              SEGMENTS  = 256,
    parameter int              FEATURES  = 16,
    parameter longint unsigned ROW_LIMIT = 64'd65536
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [OPC_W-1:0]           i_opcode,
    input  logic [SEG_W-1:0]           i_segment,
    input  logic [COL_W-1:0]           i_column,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [ROW_W-1:0]           i_source_row,
    output t_stat                      o_stat,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_max_value,
    output logic [ROW_W-1:0]           o_arg_row,
    output logic                       o_present
);

    localparam int ENTRIES = SEGMENTS * FEATURES;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Entry memory: one write port, one registered read port
    t_entry r_mem [ENTRIES];

    // Captured command beat
    logic [OPC_W-1:0]           r_op;
    logic [ADDR_W-1:0]          r_addr;
    logic                       r_loc_ok;
    logic                       r_row_ok;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [ROW_W-1:0]           r_row;
    t_entry                     r_rd;

    // Clearing pass counter
    logic [ADDR_W-1:0] r_clr_addr;

    logic [31:0]       w_pos;
    logic              w_loc_ok;
    logic              w_row_ok;
    logic [ADDR_W-1:0] w_addr;
    logic              w_take;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_entry            w_wdata;

    // Locate the entry from the incoming beat
    always_comb begin
        w_loc_ok = (32'(i_segment) < 32'(SEGMENTS)) && (32'(i_column) < 32'(FEATURES));
        w_row_ok = (64'(i_source_row) < ROW_LIMIT);
        w_pos    = 32'(i_segment) * 32'(FEATURES) + 32'(i_column);
        w_addr   = w_loc_ok ? w_pos[ADDR_W-1:0] : '0;
    end

    // Capture the beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_addr   <= w_addr;
            r_loc_ok <= w_loc_ok;
            r_row_ok <= w_row_ok;
            r_sample <= i_sample;
            r_row    <= i_source_row;
        end
    end

    // Store an in-range beat when empty or strictly greater; ties keep the earlier row
    assign w_take = r_loc_ok && r_row_ok
                 && (!r_rd.valid || (r_sample > r_rd.max_value));

    // Select write source: clearing pass or update
    always_comb begin
        if (i_cmd.sweep) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = i_cmd.exec && (r_op == OP_UPDATE) && w_take;
            w_waddr = r_addr;
            w_wdata = '{valid: 1'b1, max_value: r_sample, arg_row: r_row};
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.load) begin
            r_rd <= r_mem[w_addr];
        end
    end

    // Advance the clearing pass, wrap to zero at its end
    assign o_stat.sweep_last = (r_clr_addr == ADDR_W'(ENTRIES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.sweep) begin
            r_clr_addr <= o_stat.sweep_last ? '0 : r_clr_addr + 1'b1;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.exec && (r_op == OP_READ);
        end
    end

    // Result payload; empty or out-of-range entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_loc_ok && r_rd.valid) begin
                o_max_value <= r_rd.max_value;
                o_arg_row   <= r_rd.arg_row;
                o_present   <= 1'b1;
            end else begin
                o_max_value <= '0;
                o_arg_row   <= '0;
                o_present   <= 1'b0;
            end
        end
    end

endmodule

// File: sv/smax_checker.sv
// ============================================================================
// smax_checker
// Port-level checks of command acceptance and result timing.
// ============================================================================
module smax_checker
    import smax_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [OPC_W-1:0]           i_opcode,
    input logic                       o_valid,
    input logic signed [SAMPLE_W-1:0] o_max_value,
    input logic [ROW_W-1:0]           o_arg_row,
    input logic                       o_present
);

    logic w_beat;
    assign w_beat = start && !busy;

    // An accepted read returns its result on o_valid after the compare cycle
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && (i_opcode == OP_READ)) |-> ##2 o_valid)
        else $error("read beat without result");

    // Other accepted beats produce no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && (i_opcode != OP_READ)) |-> ##2 !o_valid)
        else $error("result without read beat");

    // An empty entry reads as zero value and zero row
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_present) |-> ((o_max_value == '0) && (o_arg_row == '0)))
        else $error("empty entry with nonzero payload");

    // A clear starts the clearing pass at once
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && (i_opcode == OP_CLEAR)) |=> busy)
        else $error("clear did not raise busy");

    // Busy stays up through the cycle that follows any accepted beat
    a_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat |=> busy)
        else $error("beat accepted back to back");

endmodule

bind segment_max_with_argmax_core smax_checker u_smax_checker (.*);
